### sv/lpfd_pkg.sv
// Package for the length-prefixed frame decoder: phase and result kind
// encodings and header byte counts. No dependencies.
`default_nettype none

package lpfd_pkg;

  // Decoder phase
  typedef enum logic [1:0] {
    PH_LEN  = 2'd0,
    PH_TYPE = 2'd1,
    PH_PAY  = 2'd2
  } phase_t;

  // Result kind
  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_BADLEN  = 2'd2
  } kind_t;

  // Header byte counter: the last byte of each header has this index
  localparam logic [1:0] LEN_LAST  = 2'd3;
  localparam logic [1:0] TYPE_LAST = 2'd1;

  // Length covered by the type field itself
  localparam logic [31:0] TYPE_BYTES = 32'd2;

endpackage : lpfd_pkg

`default_nettype wire

### sv/lpfd_if.sv
// Valid/ready channel interfaces for the frame decoder: the byte input
// channel and the result channel. Depends on lpfd_pkg.
`default_nettype none

interface lpfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface : lpfd_in_if

interface lpfd_out_if
  import lpfd_pkg::*;
;
  logic        valid;
  logic        ready;
  kind_t       kind;
  logic [15:0] msg_type;
  logic [7:0]  payload_byte;
  logic        frame_end;

  modport source (output valid, output kind, output msg_type, output payload_byte,
                  output frame_end, input ready);
  modport sink   (input valid, input kind, input msg_type, input payload_byte,
                  input frame_end, output ready);
endinterface : lpfd_out_if

`default_nettype wire

### sv/length_prefixed_frame_decoder.sv
// Length-prefixed frame decoder: 4-byte length, 2-byte type, payload bytes.
// Depends on lpfd_pkg and lpfd_if.
// A result enters the output register in the cycle after the byte that
// causes it is accepted. Throughput: one byte per cycle; input is taken
// whenever the output register is empty or being drained.
// Reset (rst_n low, synchronous): hunting for a length header, output empty.
`default_nettype none

module length_prefixed_frame_decoder
  import lpfd_pkg::*;
(
  input  wire               clk,
  input  wire               rst_n,
  lpfd_in_if.sink           in_if,
  lpfd_out_if.source        out_if
);

  // Decoder state
  phase_t      phase_r, phase_nxt;
  logic [1:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [31:0] frame_len_r, frame_len_nxt;
  logic [15:0] cur_type_r, cur_type_nxt;
  logic [31:0] bytes_left_r, bytes_left_nxt;

  // Output register
  logic        out_valid_r, out_valid_nxt;
  kind_t       kind_r, kind_nxt;
  logic [15:0] msg_type_r, msg_type_nxt;
  logic [7:0]  pay_byte_r, pay_byte_nxt;
  logic        end_r, end_nxt;

  logic        in_fire;
  logic        emit;
  logic [7:0]  b;
  logic [31:0] left_calc;
  logic [31:0] left_dec;

  assign in_if.ready = !out_valid_r || out_if.ready;
  assign in_fire     = in_if.valid && in_if.ready;
  assign b           = in_if.data_byte;

  assign left_calc = frame_len_r - TYPE_BYTES;
  assign left_dec  = bytes_left_r - 32'd1;

  // Next state and result
  always_comb begin
    phase_nxt      = phase_r;
    hdr_cnt_nxt    = hdr_cnt_r;
    frame_len_nxt  = frame_len_r;
    cur_type_nxt   = cur_type_r;
    bytes_left_nxt = bytes_left_r;
    emit           = 1'b0;
    kind_nxt       = KIND_PAYLOAD;
    msg_type_nxt   = 16'd0;
    pay_byte_nxt   = 8'd0;
    end_nxt        = 1'b0;
    if (in_fire) begin
      unique case (phase_r)
        PH_TYPE: begin
          cur_type_nxt = {cur_type_r[7:0], b};
          if (hdr_cnt_r != TYPE_LAST) begin
            hdr_cnt_nxt = hdr_cnt_r + 2'd1;
          end else begin
            hdr_cnt_nxt    = 2'd0;
            bytes_left_nxt = left_calc;
            if (left_calc == 32'd0) begin
              phase_nxt    = PH_LEN;
              emit         = 1'b1;
              kind_nxt     = KIND_EMPTY;
              msg_type_nxt = {cur_type_r[7:0], b};
              end_nxt      = 1'b1;
            end else begin
              phase_nxt = PH_PAY;
            end
          end
        end
        PH_PAY: begin
          bytes_left_nxt = left_dec;
          emit           = 1'b1;
          kind_nxt       = KIND_PAYLOAD;
          msg_type_nxt   = cur_type_r;
          pay_byte_nxt   = b;
          end_nxt        = (left_dec == 32'd0);
          if (left_dec == 32'd0) begin
            phase_nxt = PH_LEN;
          end
        end
        default: begin
          // length header; four shifts replace the whole word
          phase_nxt     = PH_LEN;
          frame_len_nxt = {frame_len_r[23:0], b};
          if (hdr_cnt_r != LEN_LAST) begin
            hdr_cnt_nxt = hdr_cnt_r + 2'd1;
          end else begin
            hdr_cnt_nxt = 2'd0;
            if (frame_len_r[23:0] == 24'd0 && b[7:1] == 7'd0) begin
              emit     = 1'b1;
              kind_nxt = KIND_BADLEN;
              end_nxt  = 1'b1;
            end else begin
              phase_nxt = PH_TYPE;
            end
          end
        end
      endcase
    end
  end

  // Output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_LEN;
      hdr_cnt_r    <= 2'd0;
      bytes_left_r <= 32'd0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      hdr_cnt_r    <= hdr_cnt_nxt;
      bytes_left_r <= bytes_left_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Header words and result payload
  always_ff @(posedge clk) begin
    frame_len_r <= frame_len_nxt;
    cur_type_r  <= cur_type_nxt;
    if (emit) begin
      kind_r     <= kind_nxt;
      msg_type_r <= msg_type_nxt;
      pay_byte_r <= pay_byte_nxt;
      end_r      <= end_nxt;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.kind         = kind_r;
  assign out_if.msg_type     = msg_type_r;
  assign out_if.payload_byte = pay_byte_r;
  assign out_if.frame_end    = end_r;

  // Checks
  a_pay_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAY |-> bytes_left_r != 32'd0)
    else $error("payload phase with no bytes left");

  a_type_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_TYPE |-> hdr_cnt_r[1] == 1'b0)
    else $error("type header count out of range");

  a_badlen_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && kind_r == KIND_BADLEN |-> msg_type_r == 16'd0 && end_r)
    else $error("bad length result malformed");

  a_nonpay_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && kind_r != KIND_PAYLOAD |-> pay_byte_r == 8'd0)
    else $error("non-payload result carries a byte");

endmodule : length_prefixed_frame_decoder

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
// Testbench for length_prefixed_frame_decoder: drives framed byte streams with random
// gaps and output stalls, and checks every result against a built-in decoder model.
// Depends on lpfd_pkg, lpfd_if and the decoder RTL.

module tb
  import lpfd_pkg::*;
;

  localparam int          CLK_PERIOD  = 20;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          RANDOM_BYTES = 2000;
  localparam int          DRAIN_EVERY = 700;
  localparam logic [2:0]  LEN_HDR_BYTES  = 3'd4;
  localparam logic [2:0]  TYPE_HDR_BYTES = 3'd2;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] msg_type;
    logic [7:0]  payload_byte;
    logic        frame_end;
  } frame_result_t;

  // Decoder model plus queue of results still owed by the block
  class frame_scoreboard;
    phase_t        phase;
    logic [2:0]    hdr_cnt;
    logic [31:0]   frame_len;
    logic [15:0]   cur_type;
    logic [31:0]   left;
    frame_result_t pending[$];
    int            errors;
    int            n_bytes;
    int            n_payload;
    int            n_empty;
    int            n_badlen;

    function new();
      phase     = PH_LEN;
      hdr_cnt   = '0;
      frame_len = '0;
      cur_type  = '0;
      left      = '0;
      errors    = 0;
      n_bytes   = 0;
      n_payload = 0;
      n_empty   = 0;
      n_badlen  = 0;
    endfunction

    // Advance the model by one accepted byte
    function void note_byte(logic [7:0] b);
      frame_result_t r;
      bit            has_result;
      has_result = 1'b0;
      r = '0;
      n_bytes++;
      case (phase)
        PH_TYPE: begin
          cur_type = {cur_type[7:0], b};
          hdr_cnt  = hdr_cnt + 3'd1;
          if (hdr_cnt == TYPE_HDR_BYTES) begin
            hdr_cnt = '0;
            left    = frame_len - TYPE_BYTES;
            if (left == 0) begin
              phase      = PH_LEN;
              r.kind     = KIND_EMPTY;
              r.msg_type = cur_type;
              r.frame_end = 1'b1;
              has_result = 1'b1;
              n_empty++;
            end else begin
              phase = PH_PAY;
            end
          end
        end
        PH_PAY: begin
          left           = left - 32'd1;
          r.kind         = KIND_PAYLOAD;
          r.msg_type     = cur_type;
          r.payload_byte = b;
          r.frame_end    = (left == 0);
          if (left == 0) phase = PH_LEN;
          has_result = 1'b1;
          n_payload++;
        end
        default: begin
          // length header; an unused phase code behaves the same
          phase = PH_LEN;
          if (hdr_cnt == 0) frame_len = '0;
          frame_len = {frame_len[23:0], b};
          hdr_cnt   = hdr_cnt + 3'd1;
          if (hdr_cnt == LEN_HDR_BYTES) begin
            hdr_cnt = '0;
            if (frame_len < TYPE_BYTES) begin
              r.kind      = KIND_BADLEN;
              r.frame_end = 1'b1;
              has_result  = 1'b1;
              n_badlen++;
            end else begin
              phase    = PH_TYPE;
              cur_type = '0;
            end
          end
        end
      endcase
      if (has_result) pending = {pending, r};
    endfunction

    // Compare one accepted result with the oldest expectation
    function void check_result(frame_result_t got);
      frame_result_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result kind=%0d type=%h byte=%h end=%b", $time,
                 got.kind, got.msg_type, got.payload_byte, got.frame_end);
        return;
      end
      want = pending.pop_front();
      if (got.kind !== want.kind) begin
        errors++;
        $display("%0t: kind mismatch: expected %0d, got %0d", $time, want.kind, got.kind);
      end
      if (got.msg_type !== want.msg_type) begin
        errors++;
        $display("%0t: msg_type mismatch: expected %h, got %h", $time,
                 want.msg_type, got.msg_type);
      end
      if (got.payload_byte !== want.payload_byte) begin
        errors++;
        $display("%0t: payload_byte mismatch: expected %h, got %h", $time,
                 want.payload_byte, got.payload_byte);
      end
      if (got.frame_end !== want.frame_end) begin
        errors++;
        $display("%0t: frame_end mismatch: expected %b, got %b", $time,
                 want.frame_end, got.frame_end);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   cycle_cnt;
  int   n_checked;
  bit   tx_idle_on;
  bit   rx_idle_on;
  frame_scoreboard sb;

  lpfd_in_if  in_ch ();
  lpfd_out_if out_ch ();

  length_prefixed_frame_decoder i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Run limit
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Send one byte; optional idle cycles first
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 5) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
    end
    @(negedge clk);
    in_ch.valid     = 1'b1;
    in_ch.data_byte = b;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_byte(b);
  endtask

  // Length header, type header (unless the length is bad), then n_pay payload bytes
  task automatic send_frame(input logic [31:0] len, input logic [15:0] typ, input int n_pay);
    for (int i = 3; i >= 0; i--) send_byte(len[8*i +: 8]);
    if (len < TYPE_BYTES) return;
    send_byte(typ[15:8]);
    send_byte(typ[7:0]);
    for (int i = 0; i < n_pay; i++) send_byte(8'($urandom_range(0, 255)));
  endtask

  // Hold the input off until every owed result has come out
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // Result side: random stalls, check every accepted item
  initial begin
    frame_result_t got;
    int stall;
    out_ch.ready = 1'b0;
    rx_idle_on   = 1'b1;
    n_checked    = 0;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 49) == 0) rx_idle_on = ~rx_idle_on;
      stall = rx_idle_on ? $urandom_range(0, 5) : 0;
      repeat (stall) begin
        @(negedge clk);
        out_ch.ready = 1'b0;
      end
      @(negedge clk);
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got.kind         = out_ch.kind;
      got.msg_type     = out_ch.msg_type;
      got.payload_byte = out_ch.payload_byte;
      got.frame_end    = out_ch.frame_end;
      sb.check_result(got);
      n_checked++;
    end
  end

  // Stimulus
  initial begin
    int          sel;
    int          next_drain;
    logic [31:0] len;
    sb = new();
    tx_idle_on      = 1'b1;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    rst_n           = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: bad lengths 0 and 1, empty frame, short frame with extreme bytes
    send_frame(32'd0, 16'h0000, 0);
    send_frame(32'd1, 16'h0000, 0);
    send_frame(32'd2, 16'hFFFF, 0);
    send_frame(32'd4, 16'h8001, 0);
    send_byte(8'hFF);
    send_byte(8'h00);
    wait_drained();

    // Random: mostly well-formed frames, some bad lengths, occasional long frames
    next_drain = sb.n_bytes + DRAIN_EVERY;
    while (sb.n_bytes < RANDOM_BYTES) begin
      if ($urandom_range(0, 7) == 0) tx_idle_on = ~tx_idle_on;
      sel = $urandom_range(0, 99);
      if (sel < 8)       len = $urandom_range(0, 1);
      else if (sel < 16) len = 32'd2;
      else if (sel < 95) len = $urandom_range(3, 24);
      else               len = $urandom_range(25, 300);
      send_frame(len, 16'($urandom_range(0, 16'hFFFF)), (len < TYPE_BYTES) ? 0 : len - 2);
      if (sb.n_bytes >= next_drain) begin
        wait_drained();
        next_drain = sb.n_bytes + DRAIN_EVERY;
      end
    end

    // Maximum length: the frame stays open for the rest of the run
    send_frame(32'hFFFF_FFFF, 16'($urandom_range(0, 16'hFFFF)), 40);
    @(negedge clk);
    in_ch.valid = 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Run covered %0d input bytes and %0d checked results:", sb.n_bytes, n_checked);
    $display("  %0d payload bytes, %0d empty frames, %0d bad lengths",
             sb.n_payload, sb.n_empty, sb.n_badlen);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule : tb
